// ===== sv/nbge_pkg.sv =====
// ----------------------------------------------------------------------------
// nbge_pkg
// Shared types, widths and helpers for the n-body Euler step core.
// ----------------------------------------------------------------------------
package nbge_pkg;

    localparam int NUM_BODIES_DEF = 3;

    // operation codes carried in s_tuser
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    localparam int COORD_W = 32;   // Q16.16
    localparam int MASS_W  = 16;   // Q8.8
    localparam int DIFF_W  = 33;   // exact coordinate difference
    localparam int SQ_W    = 66;   // dx^2 + dy^2
    localparam int ROOT_W  = 33;   // floor(sqrt(r2))
    localparam int NUM_W   = 74;   // dividend width
    localparam int QUO_W   = 41;   // quotient width, holds the 2^40 cap
    localparam int ACC_W   = 46;   // sum of pair terms
    localparam int SUM_W   = 47;   // velocity plus sum

    localparam logic [QUO_W-1:0] ACC_CAP = {1'b1, {(QUO_W-1){1'b0}}};

    typedef struct packed {
        logic [MASS_W-1:0]  mass;
        logic [COORD_W-1:0] vy;
        logic [COORD_W-1:0] vx;
        logic [COORD_W-1:0] py;
        logic [COORD_W-1:0] px;
    } body_t;

    function automatic logic [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic [COORD_W-1:0] r;
        if (v > SUM_W'(signed'(33'sh0_7FFF_FFFF)))
            r = 32'h7FFF_FFFF;
        else if (v < SUM_W'(signed'(33'sh1_8000_0000)))
            r = 32'h8000_0000;
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

    function automatic logic [DIFF_W-1:0] mag33(input logic signed [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] r;
        r = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
        return r;
    endfunction

endpackage

// ===== sv/nbge_div.sv =====
// ----------------------------------------------------------------------------
// nbge_div
// Restoring divider, one quotient bit per cycle, result capped at 2^40.
// ----------------------------------------------------------------------------
module nbge_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [nbge_pkg::NUM_W-1:0]  num,
    input  logic [nbge_pkg::SQ_W-1:0]   den,
    output logic                        busy,
    output logic [nbge_pkg::QUO_W-1:0]  quot
);
    import nbge_pkg::*;

    logic             busy_reg;
    logic [5:0]       cnt_reg;
    logic [SQ_W-1:0]  rem_reg;
    logic [SQ_W-1:0]  den_reg;
    logic [QUO_W-1:0] nlo_reg;
    logic [QUO_W-1:0] q_reg;
    logic             ovf_reg;
    logic [SQ_W:0]    trial;
    logic [SQ_W:0]    diff;
    logic             ge;
    logic [SQ_W-1:0]  rem0;

    // top bits of the dividend are preloaded; if they already reach the
    // divisor the quotient is at least 2^41 and the cap applies
    assign rem0  = SQ_W'(num[NUM_W-1:QUO_W]);
    assign trial = {rem_reg, nlo_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'(QUO_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem0;
            den_reg <= den;
            nlo_reg <= num[QUO_W-1:0];
            q_reg   <= '0;
            ovf_reg <= rem0 >= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[SQ_W-1:0] : trial[SQ_W-1:0];
            q_reg   <= {q_reg[QUO_W-2:0], ge};
            nlo_reg <= {nlo_reg[QUO_W-2:0], 1'b0};
        end
    end

    assign busy = busy_reg;
    assign quot = (ovf_reg || (q_reg > ACC_CAP)) ? ACC_CAP : q_reg;

endmodule

// ===== sv/nbge_sqrt.sv =====
// ----------------------------------------------------------------------------
// nbge_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module nbge_sqrt
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [nbge_pkg::SQ_W-1:0]    radicand,
    output logic                         busy,
    output logic [nbge_pkg::ROOT_W-1:0]  root
);
    import nbge_pkg::*;

    logic            busy_reg;
    logic [5:0]      cnt_reg;
    logic [SQ_W-1:0] op_reg;
    logic [SQ_W-1:0] res_reg;
    logic [SQ_W-1:0] one_reg;
    logic [SQ_W:0]   sum;
    logic            ge;

    assign sum = {1'b0, res_reg} + {1'b0, one_reg};
    assign ge  = {1'b0, op_reg} >= sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'(SQ_W / 2);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg  <= radicand;
            res_reg <= '0;
            one_reg <= {2'b01, {(SQ_W-2){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                op_reg  <= op_reg - sum[SQ_W-1:0];
                res_reg <= (res_reg >> 1) + one_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            one_reg <= one_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

// ===== sv/nbody_gravity_euler_step_core.sv =====
// Load transfer: no result. Step transfer: three divider waits per ordered body
// pair (root beside the first; none if coincident), then a position update and
// an output per body. One item at a time; s_tready is high while idle.
// Reset clears the body state to zero through per-entry valid bits and sets
// grav_const to 5000.0.
// ----------------------------------------------------------------------------
// nbody_gravity_euler_step_core
// 2D gravity n-body semi-implicit Euler step over a body-state memory.
// ----------------------------------------------------------------------------
module nbody_gravity_euler_step_core #(
    parameter int NUM_BODIES = nbge_pkg::NUM_BODIES_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // [1:0] body_index, [33:2] pos_x, [65:34] pos_y, [97:66] vel_x,
    // [129:98] vel_y, [145:130] body_mass, [151:146] zero
    input  logic [151:0]  s_tdata,
    input  logic          s_tuser,      // func
    output logic          m_tvalid,
    input  logic          m_tready,
    // [1:0] out_index, [33:2] new_pos_x, [65:34] new_pos_y, [97:66] new_vel_x,
    // [129:98] new_vel_y, [135:130] zero
    output logic [135:0]  m_tdata,
    output logic          m_tlast,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [31:0]   cfg_data
);
    import nbge_pkg::*;

    localparam int IDX_W = (NUM_BODIES > 2) ? $clog2(NUM_BODIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BODIES - 1);

    typedef enum logic [21:0] {
        S_IDLE   = 22'h000001,
        S_RD_I   = 22'h000002,
        S_LAT_I  = 22'h000004,
        S_RD_J   = 22'h000008,
        S_LAT_J  = 22'h000010,
        S_SQ_X   = 22'h000020,
        S_SQ_Y   = 22'h000040,
        S_GM     = 22'h000080,
        S_CHK    = 22'h000100,
        S_WAIT_A = 22'h000200,
        S_AX_LO  = 22'h000400,
        S_AX_HI  = 22'h000800,
        S_AX_DIV = 22'h001000,
        S_WAIT_X = 22'h002000,
        S_AY_LO  = 22'h004000,
        S_AY_HI  = 22'h008000,
        S_AY_DIV = 22'h010000,
        S_WAIT_Y = 22'h020000,
        S_NEXT_J = 22'h040000,
        S_WB_VEL = 22'h080000,
        S_UP_RD  = 22'h100000,
        S_UP_LAT = 22'h200000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0]      grav_reg;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;

    // body memory, synchronous read
    body_t                 mem [NUM_BODIES];
    logic [NUM_BODIES-1:0] valid_reg;
    body_t                 mem_q_reg;
    logic                  rvalid_reg;
    body_t                 rdata;
    logic                  we;
    logic [IDX_W-1:0]      wa;
    logic [IDX_W-1:0]      ra;
    body_t                 wd;

    // pair datapath
    body_t                     pi_reg;
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg;
    logic [MASS_W-1:0]         mj_reg;
    logic [SQ_W-1:0]           r2_reg;
    logic [QUO_W-1:0]          a_reg;
    logic [ROOT_W-1:0]         d_reg;
    logic [64:0]               prod_lo_reg;
    logic signed [ACC_W-1:0]   acc_x_reg, acc_y_reg;
    logic [DIFF_W-1:0]         mag_x, mag_y;
    logic [DIFF_W-1:0]         mul_a, mul_b;
    logic [SQ_W-1:0]           mul_p_reg;
    logic signed [DIFF_W-1:0]  dx_new, dy_new;
    logic signed [ACC_W-1:0]   term;

    // units
    logic              div_start, div_busy;
    logic [NUM_W-1:0]  div_num;
    logic [SQ_W-1:0]   div_den;
    logic [QUO_W-1:0]  div_quot;
    logic              sq_start, sq_busy;
    logic [ROOT_W-1:0] sq_root;

    // load decode
    logic             load_hit;
    logic [IDX_W-1:0] load_idx;
    body_t            load_body;

    // update
    logic [COORD_W-1:0] nvx, nvy, npx, npy;
    logic               out_free;
    logic               m_valid_reg;
    logic [1:0]         out_idx_reg;
    logic [COORD_W-1:0] out_px_reg, out_py_reg, out_vx_reg, out_vy_reg;
    logic               out_last_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);

    assign load_idx  = IDX_W'(s_tdata[1:0]);
    assign load_hit  = s_tvalid && (s_tuser == FUNC_LOAD) &&
                       ({30'd0, s_tdata[1:0]} < 32'(NUM_BODIES));
    assign load_body = '{mass: s_tdata[145:130], vy: s_tdata[129:98],
                         vx: s_tdata[97:66], py: s_tdata[65:34], px: s_tdata[33:2]};

    assign rdata = rvalid_reg ? mem_q_reg : '0;
    assign ra    = (state_reg == S_RD_J) ? j_reg : i_reg;

    assign mag_x  = mag33(dx_reg);
    assign mag_y  = mag33(dy_reg);
    assign dx_new = {rdata.px[31], rdata.px} - {pi_reg.px[31], pi_reg.px};
    assign dy_new = {rdata.py[31], rdata.py} - {pi_reg.py[31], pi_reg.py};

    assign nvx = sat32(SUM_W'(signed'(pi_reg.vx)) + SUM_W'(acc_x_reg));
    assign nvy = sat32(SUM_W'(signed'(pi_reg.vy)) + SUM_W'(acc_y_reg));
    assign npx = sat32(SUM_W'(signed'(rdata.px)) + SUM_W'(signed'(rdata.vx)));
    assign npy = sat32(SUM_W'(signed'(rdata.py)) + SUM_W'(signed'(rdata.vy)));

    assign out_free = !m_valid_reg || m_tready;
    assign term     = ACC_W'(div_quot);

    // memory
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        mem_q_reg <= mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
                valid_reg[wa] <= 1'b1;
            rvalid_reg <= valid_reg[ra];
        end
    end

    // one shared 33x33 multiplier, registered
    always_comb
    begin
        mul_a = mag_x;
        mul_b = mag_x;
        case (state_reg)
            S_SQ_Y:
            begin
                mul_a = mag_y;
                mul_b = mag_y;
            end
            S_GM:
            begin
                mul_a = DIFF_W'(grav_reg);
                mul_b = DIFF_W'(mj_reg);
            end
            S_AX_LO:
            begin
                mul_a = DIFF_W'(a_reg[31:0]);
                mul_b = mag_x;
            end
            S_AX_HI:
            begin
                mul_a = DIFF_W'(a_reg[QUO_W-1:32]);
                mul_b = mag_x;
            end
            S_AY_LO:
            begin
                mul_a = DIFF_W'(a_reg[31:0]);
                mul_b = mag_y;
            end
            S_AY_HI:
            begin
                mul_a = DIFF_W'(a_reg[QUO_W-1:32]);
                mul_b = mag_y;
            end
            default:
            begin
                mul_a = mag_x;
                mul_b = mag_x;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mul_p_reg <= mul_a * mul_b;
    end

    // divider feed
    always_comb
    begin
        div_start = 1'b0;
        div_num   = {2'b00, mul_p_reg[47:0], 24'd0};
        div_den   = r2_reg;
        sq_start  = 1'b0;
        case (state_reg)
            S_CHK:
            begin
                div_start = (r2_reg != '0);
                sq_start  = (r2_reg != '0);
            end
            S_AX_DIV, S_AY_DIV:
            begin
                div_start = 1'b1;
                div_num   = {9'd0, prod_lo_reg} + {mul_p_reg[41:0], 32'd0};
                div_den   = SQ_W'(d_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    nbge_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    nbge_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (r2_reg),
        .busy     (sq_busy),
        .root     (sq_root)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        we         = 1'b0;
        wa         = i_reg;
        wd         = load_body;
        unique case (state_reg)
            S_IDLE:
            begin
                wa = load_idx;
                we = load_hit;
                if (s_tvalid && (s_tuser == FUNC_STEP))
                begin
                    i_next     = '0;
                    state_next = S_RD_I;
                end
            end
            S_RD_I:   state_next = S_LAT_I;
            S_LAT_I:
            begin
                j_next     = '0;
                state_next = S_RD_J;
            end
            S_RD_J:   state_next = (j_reg == i_reg) ? S_NEXT_J : S_LAT_J;
            S_LAT_J:  state_next = S_SQ_X;
            S_SQ_X:   state_next = S_SQ_Y;
            S_SQ_Y:   state_next = S_GM;
            S_GM:     state_next = S_CHK;
            S_CHK:    state_next = (r2_reg == '0) ? S_NEXT_J : S_WAIT_A;
            S_WAIT_A: state_next = (!div_busy && !sq_busy) ? S_AX_LO : S_WAIT_A;
            S_AX_LO:  state_next = S_AX_HI;
            S_AX_HI:  state_next = S_AX_DIV;
            S_AX_DIV: state_next = S_WAIT_X;
            S_WAIT_X: state_next = div_busy ? S_WAIT_X : S_AY_LO;
            S_AY_LO:  state_next = S_AY_HI;
            S_AY_HI:  state_next = S_AY_DIV;
            S_AY_DIV: state_next = S_WAIT_Y;
            S_WAIT_Y: state_next = div_busy ? S_WAIT_Y : S_NEXT_J;
            S_NEXT_J:
            begin
                if (j_reg == LAST_IDX)
                begin
                    state_next = S_WB_VEL;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_RD_J;
                end
            end
            S_WB_VEL:
            begin
                // velocity only feeds its own body, so it goes back right away
                we = 1'b1;
                wd = '{mass: pi_reg.mass, vy: nvy, vx: nvx, py: pi_reg.py, px: pi_reg.px};
                if (i_reg == LAST_IDX)
                begin
                    i_next     = '0;
                    state_next = S_UP_RD;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_RD_I;
                end
            end
            S_UP_RD:  state_next = S_UP_LAT;
            S_UP_LAT:
            begin
                wd = '{mass: rdata.mass, vy: rdata.vy, vx: rdata.vx, py: npy, px: npx};
                if (out_free)
                begin
                    we = 1'b1;
                    if (i_reg == LAST_IDX)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_UP_RD;
                    end
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            grav_reg    <= 32'd327680000;
            i_reg       <= '0;
            j_reg       <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            if (cfg_valid)
                grav_reg <= cfg_data;
            if ((state_reg == S_UP_LAT) && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_LAT_I:
            begin
                pi_reg    <= rdata;
                acc_x_reg <= '0;
                acc_y_reg <= '0;
            end
            S_LAT_J:
            begin
                dx_reg <= dx_new;
                dy_reg <= dy_new;
                mj_reg <= rdata.mass;
            end
            S_SQ_Y:   r2_reg <= mul_p_reg;
            S_GM:     r2_reg <= r2_reg + mul_p_reg;
            S_WAIT_A:
            begin
                a_reg <= div_quot;
                d_reg <= sq_root;
            end
            S_AX_HI, S_AY_HI: prod_lo_reg <= mul_p_reg[64:0];
            S_WAIT_X:
            begin
                if (!div_busy)
                    acc_x_reg <= dx_reg[DIFF_W-1] ? acc_x_reg - term : acc_x_reg + term;
            end
            S_WAIT_Y:
            begin
                if (!div_busy)
                    acc_y_reg <= dy_reg[DIFF_W-1] ? acc_y_reg - term : acc_y_reg + term;
            end
            S_UP_LAT:
            begin
                if (out_free)
                begin
                    out_idx_reg  <= 2'(i_reg);
                    out_px_reg   <= npx;
                    out_py_reg   <= npy;
                    out_vx_reg   <= rdata.vx;
                    out_vy_reg   <= rdata.vy;
                    out_last_reg <= (i_reg == LAST_IDX);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'd0, out_vy_reg, out_vx_reg, out_py_reg, out_px_reg, out_idx_reg};

endmodule

// ===== tb/nbody_gravity_euler_step_core_tb.sv =====
// ----------------------------------------------------------------------------
// nbody_gravity_euler_step_core_tb
// Body loads and Euler steps with random content, stalls on both streams and
// several gravity constants. Each step's per-body state is predicted here and
// compared field by field.
// ----------------------------------------------------------------------------
module nbody_gravity_euler_step_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import nbge_pkg::*;

    localparam int NB = NUM_BODIES_DEF;
    localparam logic [40:0] FORCE_CAP = {1'b1, 40'd0};
    localparam logic [31:0] GRAV_DEFAULT = 32'd327680000;

    typedef struct {
        logic [1:0]  idx;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] vx;
        logic [31:0] vy;
        logic        last;
    } body_report_t;

    class step_scoreboard;
        logic [31:0]  grav;
        logic [31:0]  px[NB];
        logic [31:0]  py[NB];
        logic [31:0]  vx[NB];
        logic [31:0]  vy[NB];
        logic [15:0]  mass[NB];
        body_report_t expected_bodies[$];
        int           errors;
        int           results;

        function new();
            grav = GRAV_DEFAULT;
            errors = 0;
            results = 0;
            for (int i = 0; i < NB; i++)
            begin
                px[i] = '0; py[i] = '0; vx[i] = '0; vy[i] = '0; mass[i] = '0;
            end
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function logic [31:0] clamp32(longint v);
            if (v > 64'sh7FFF_FFFF)
                return 32'h7FFF_FFFF;
            if (v < -64'sh8000_0000)
                return 32'h8000_0000;
            return v[31:0];
        endfunction

        function logic [127:0] root_floor(logic [127:0] v);
            logic [127:0] res;
            logic [127:0] t;
            res = '0;
            for (int b = 33; b >= 0; b--)
            begin
                t = res | (128'd1 << b);
                if (t * t <= v)
                    res = t;
            end
            return res;
        endfunction

        function logic [127:0] div_capped(logic [127:0] n, logic [127:0] d);
            logic [127:0] q;
            q = n / d;
            return (q > FORCE_CAP) ? 128'(FORCE_CAP) : q;
        endfunction

        // pair forces use the positions from before the step
        function void run_step();
            longint acc_x[NB];
            longint acc_y[NB];
            longint dx, dy;
            logic [127:0] mx, my, r2, root_d, gm, accel, cx, cy;
            for (int i = 0; i < NB; i++)
            begin
                acc_x[i] = 0;
                acc_y[i] = 0;
                for (int j = 0; j < NB; j++)
                begin
                    if (i == j)
                        continue;
                    dx = longint'($signed(px[j])) - longint'($signed(px[i]));
                    dy = longint'($signed(py[j])) - longint'($signed(py[i]));
                    mx = 128'(dx < 0 ? -dx : dx);
                    my = 128'(dy < 0 ? -dy : dy);
                    r2 = mx * mx + my * my;
                    if (r2 == 0)
                        continue;   // coincident bodies exert nothing
                    root_d = root_floor(r2);
                    gm = 128'(grav) * 128'(mass[j]);
                    accel = div_capped(gm << 24, r2);
                    cx = div_capped(accel * mx, root_d);
                    cy = div_capped(accel * my, root_d);
                    acc_x[i] += dx < 0 ? -longint'(cx) : longint'(cx);
                    acc_y[i] += dy < 0 ? -longint'(cy) : longint'(cy);
                end
            end
            for (int i = 0; i < NB; i++)
            begin
                body_report_t r;
                vx[i] = clamp32(longint'($signed(vx[i])) + acc_x[i]);
                vy[i] = clamp32(longint'($signed(vy[i])) + acc_y[i]);
                px[i] = clamp32(longint'($signed(px[i])) + longint'($signed(vx[i])));
                py[i] = clamp32(longint'($signed(py[i])) + longint'($signed(vy[i])));
                r.idx = 2'(i);
                r.px = px[i]; r.py = py[i]; r.vx = vx[i]; r.vy = vy[i];
                r.last = (i == NB - 1);
                expected_bodies.push_back(r);
            end
        endfunction

        function void note_input(logic func, logic [151:0] d);
            int idx;
            if (func == FUNC_STEP)
            begin
                run_step();
                return;
            end
            idx = int'(d[1:0]);
            if (idx >= NB)
                return;
            px[idx] = d[33:2];
            py[idx] = d[65:34];
            vx[idx] = d[97:66];
            vy[idx] = d[129:98];
            mass[idx] = d[145:130];
        endfunction

        task check(logic [135:0] d, logic tl);
            body_report_t e;
            results++;
            if (expected_bodies.size() == 0)
            begin
                report($sformatf("unexpected body result %h", d));
                return;
            end
            e = expected_bodies.pop_front();
            if (d[1:0] != e.idx)
                report($sformatf("index got %0d exp %0d", d[1:0], e.idx));
            if (d[33:2] != e.px)
                report($sformatf("body %0d pos_x got %h exp %h", e.idx, d[33:2], e.px));
            if (d[65:34] != e.py)
                report($sformatf("body %0d pos_y got %h exp %h", e.idx, d[65:34], e.py));
            if (d[97:66] != e.vx)
                report($sformatf("body %0d vel_x got %h exp %h", e.idx, d[97:66], e.vx));
            if (d[129:98] != e.vy)
                report($sformatf("body %0d vel_y got %h exp %h", e.idx, d[129:98], e.vy));
            if (tl != e.last)
                report($sformatf("body %0d tlast got %0b exp %0b", e.idx, tl, e.last));
        endtask
    endclass

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [151:0]  s_tdata;
    logic          s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [135:0]  m_tdata;
    logic          m_tlast;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [31:0]   cfg_data;

    step_scoreboard sb;
    int idle_mode;      // 0 none, 1 sender gaps, 2 receiver stalls, 3 both
    int n_steps, n_loads, n_cfg;

    nbody_gravity_euler_step_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        int pct;
        pct = (idle_mode == 2) ? 46 : (idle_mode == 3) ? 16 : 0;
        m_tready <= ($urandom_range(99) >= pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check(m_tdata, m_tlast);
    end

    task automatic send_item(logic func, logic [1:0] idx, logic [31:0] px,
                             logic [31:0] py, logic [31:0] vx, logic [31:0] vy,
                             logic [15:0] m);
        logic [151:0] d;
        int pct;
        d = {6'd0, m, vy, vx, py, px, idx};
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= func;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(func, d);
        if (func == FUNC_STEP)
            n_steps++;
        else
            n_loads++;
        pct = (idle_mode == 1) ? 46 : (idle_mode == 3) ? 16 : 0;
        if ($urandom_range(99) < pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic step_bodies();
        send_item(FUNC_STEP, 2'($urandom), $urandom, $urandom, $urandom, $urandom,
                  16'($urandom));
    endtask

    // lets the pipe drain so a register write lands on an idle core
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.expected_bodies.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_grav(logic [31:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.grav = v;
        n_cfg++;
    endtask

    // mostly near-field coordinates so forces matter, sometimes full range
    function automatic logic [31:0] rand_coord();
        if ($urandom_range(3) == 0)
            return $urandom;
        return 32'($urandom_range(0, 32'h40_0000)) - 32'h20_0000;
    endfunction

    task automatic load_body(logic [1:0] idx);
        send_item(FUNC_LOAD, idx, rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), 16'($urandom));
    endtask

    task automatic random_grav();
        case ($urandom_range(4))
            0: write_grav(32'd0);
            1: write_grav(32'hFFFF_FFFF);
            2: write_grav(GRAV_DEFAULT);
            default: write_grav($urandom);
        endcase
    endtask

    initial
    begin
        int sent;
        sb = new();
        idle_mode = 0;
        n_steps = 0; n_loads = 0; n_cfg = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = FUNC_LOAD;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty bodies, then extremes with saturation
        step_bodies();
        send_item(FUNC_LOAD, 2'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 16'hFFFF);
        send_item(FUNC_LOAD, 2'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 16'hFFFF);
        send_item(FUNC_LOAD, 2'd2, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0);
        step_bodies();
        // load to a body index that does not exist
        send_item(FUNC_LOAD, 2'(NB), '1, '1, '1, '1, '1);
        step_bodies();
        // coincident pair plus a close neighbor, max constant hits the cap
        write_grav(32'hFFFF_FFFF);
        send_item(FUNC_LOAD, 2'd0, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 16'hFFFF);
        send_item(FUNC_LOAD, 2'd1, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 16'h0100);
        send_item(FUNC_LOAD, 2'd2, 32'h0, 32'h0000_0001, 32'h0, 32'h0, 16'h0001);
        step_bodies();
        step_bodies();
        write_grav(32'd0);
        step_bodies();
        write_grav(GRAV_DEFAULT);
        for (int i = 0; i < NB; i++)
            send_item(FUNC_LOAD, 2'(i), 32'h0004_0000 * i, 32'hFFFE_0000, 32'h0,
                      32'h0000_8000, 16'h0100);
        step_bodies();
        step_bodies();

        // random, phase by phase through the idle modes
        sent = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            random_grav();
            idle_mode = ph;
            while (sent < 23 * (ph + 1))
            begin
                if ($urandom_range(9) == 0)
                begin
                    // noise: stray load, possibly out of range
                    load_body(2'($urandom));
                    sent++;
                end
                else
                begin
                    int n_step;
                    n_step = int'($urandom_range(1, 3));
                    for (int i = 0; i < NB; i++)
                        load_body(2'(i));
                    repeat (n_step) step_bodies();
                    sent += NB + n_step;
                end
                if ($urandom_range(7) == 0)
                    wait_idle();
            end
        end

        wait_idle();
        repeat (50) @(posedge clk);
        $display("covered %0d steps, %0d loads, %0d constant writes, %0d body results",
                 n_steps, n_loads, n_cfg, sb.results);
        if (sb.errors == 0 && sb.expected_bodies.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
